### design/lri_pkg.sv
// Shared types, constants and the sigmoid table for the logistic regression datapath.
package lri_pkg;

  localparam int MAX_FEATURES    = 64;
  localparam int SIGMOID_ENTRIES = 256;

  localparam int POS_W     = $clog2(MAX_FEATURES);
  localparam int CNT_W     = $clog2(MAX_FEATURES + 1);
  localparam int SIG_IDX_W = $clog2(SIGMOID_ENTRIES);

  localparam int VAL_W  = 16;
  localparam int WIDX_W = 6;
  localparam int FC_W   = 7;
  localparam int PROB_W = 16;
  localparam int FRAC_W = 12;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 40;
  localparam int SUM_W  = ACC_W + 1;

  localparam int RES_DEPTH = 8;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam int CFG_IDX_W = 1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // z offset of +8 and the width of the table span [-8,8) in Q17.24
  localparam logic signed [SUM_W-1:0] SIG_Z_OFFSET = SUM_W'(64'sd8 <<< (2 * FRAC_W));
  localparam logic signed [SUM_W-1:0] SIG_Z_SPAN   = SUM_W'(64'sd16 <<< (2 * FRAC_W));
  localparam int SIG_IDX_MSB = 2 * FRAC_W + 3;

  localparam logic [63:0] Q30_ONE         = 64'd1 << 30;
  localparam logic [63:0] EXP_NEG_ONE_Q30 = 64'd395007542;
  localparam logic [63:0] PROB_FULL       = 64'd65535;

  typedef enum logic {
    KIND_FEATURE = 1'b0,
    KIND_WEIGHT  = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIAS          = 1'b0,
    CFG_FEATURE_COUNT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic vld;
    logic first;
    logic fin;
    logic batch_last;
  } tag_t;

  typedef struct packed {
    logic vld;
    logic batch_last;
  } done_t;

  typedef struct packed {
    logic              class_one;
    logic [PROB_W-1:0] prob_one;
    logic              batch_end;
  } res_t;

  typedef logic [SIGMOID_ENTRIES-1:0][PROB_W-1:0] sig_table_t;

  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [PROB_W-1:0] sig_entry(int k);
    int          d;
    logic        nonneg;
    logic [63:0] mag;
    logic [63:0] a;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] e;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] den;
    logic [63:0] num;
    d      = 2 * k + 1 - SIGMOID_ENTRIES;
    nonneg = (d >= 0);
    mag    = nonneg ? 64'(d) : 64'(-d);
    a      = (mag << 33) / 64'(SIGMOID_ENTRIES);
    n      = a >> 30;
    f      = a & (Q30_ONE - 64'd1);
    e      = Q30_ONE;
    term   = Q30_ONE;
    for (int i = 1; i <= 24; i++) begin
      term = udiv64((term * f) >> 30, 64'(i));
      e    = e + term;
    end
    r = udiv64(64'd1 << 60, e);
    for (int i = 0; i < 8; i++) begin
      if (64'(i) < n) begin
        r = (r * EXP_NEG_ONE_Q30) >> 30;
      end
    end
    den = Q30_ONE + r;
    num = nonneg ? PROB_FULL * Q30_ONE : PROB_FULL * r;
    return PROB_W'(udiv64(num + (den >> 1), den));
  endfunction

  function automatic sig_table_t build_sig_table();
    sig_table_t tbl;
    for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
      tbl[k] = sig_entry(k);
    end
    return tbl;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

### design/lri_weight_mem.sv
// Weight store: single write port, registered read port.
module lri_weight_mem (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic        [lri_pkg::POS_W-1:0]     waddr_i,
  input  logic signed [lri_pkg::VAL_W-1:0]     wdata_i,
  input  logic                                 re_i,
  input  logic        [lri_pkg::POS_W-1:0]     raddr_i,
  output logic signed [lri_pkg::VAL_W-1:0]     rdata_o
);

  logic signed [lri_pkg::VAL_W-1:0] mem_q [lri_pkg::MAX_FEATURES];
  logic signed [lri_pkg::VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/lri_mac.sv
// Multiply stage and saturating 40-bit accumulator.
module lri_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lri_pkg::tag_t                        tag_i,
  input  logic signed [lri_pkg::VAL_W-1:0]     value_i,
  input  logic signed [lri_pkg::VAL_W-1:0]     weight_i,
  input  logic signed [lri_pkg::VAL_W-1:0]     bias_i,
  output logic signed [lri_pkg::ACC_W-1:0]     acc_o,
  output lri_pkg::done_t                       done_o
);

  lri_pkg::tag_t                       tag_q;
  logic signed [lri_pkg::PROD_W-1:0]   prod_q;
  logic signed [lri_pkg::ACC_W-1:0]    acc_q, acc_d;
  lri_pkg::done_t                      done_q, done_d;
  logic signed [lri_pkg::ACC_W-1:0]    bias_ext;
  logic signed [lri_pkg::ACC_W-1:0]    base;
  logic signed [lri_pkg::SUM_W-1:0]    sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_i.vld) begin
      prod_q <= value_i * weight_i;
    end
  end

  always_comb begin
    bias_ext = lri_pkg::ACC_W'(bias_i) <<< lri_pkg::FRAC_W;
    base     = tag_q.first ? bias_ext : acc_q;
    sum      = lri_pkg::SUM_W'(base) + lri_pkg::SUM_W'(prod_q);
    acc_d    = acc_q;
    if (tag_q.vld) begin
      if (sum[lri_pkg::SUM_W-1] != sum[lri_pkg::SUM_W-2]) begin
        acc_d = sum[lri_pkg::SUM_W-1] ? lri_pkg::ACC_MIN : lri_pkg::ACC_MAX;
      end else begin
        acc_d = sum[lri_pkg::ACC_W-1:0];
      end
    end
    done_d.vld        = tag_q.vld & tag_q.fin;
    done_d.batch_last = tag_q.batch_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      done_q <= '0;
    end else begin
      acc_q  <= acc_d;
      done_q <= done_d;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

  a_done_follows_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q.vld |-> $past(tag_q.vld) && $past(tag_q.fin))
    else $error("result issued without a final feature");

endmodule

### design/lri_out_stage.sv
// Sigmoid lookup, result queue and result credit tracking.
module lri_out_stage (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic signed [lri_pkg::ACC_W-1:0]        acc_i,
  input  lri_pkg::done_t                          done_i,
  input  logic                                    claim_i,
  output logic                                    full_o,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic                                    out_class_one_o,
  output logic        [lri_pkg::PROB_W-1:0]       out_prob_one_o,
  output logic        [lri_pkg::PROB_W-1:0]       out_prob_zero_o,
  output logic                                    out_batch_end_o
);

  logic signed [lri_pkg::SUM_W-1:0]     z_off;
  logic        [lri_pkg::SIG_IDX_W-1:0] sig_idx;
  lri_pkg::res_t                        entry;
  lri_pkg::res_t                        fifo_q [lri_pkg::RES_DEPTH];
  lri_pkg::res_t                        head;
  logic [lri_pkg::RES_PTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [lri_pkg::RES_PTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [lri_pkg::RES_CNT_W-1:0]        fill_q, fill_d;
  logic [lri_pkg::RES_CNT_W-1:0]        cred_q, cred_d;
  logic                                 push, pop;

  always_comb begin
    z_off = lri_pkg::SUM_W'(acc_i) + lri_pkg::SIG_Z_OFFSET;
    if (z_off < 0) begin
      sig_idx = '0;
    end else if (z_off >= lri_pkg::SIG_Z_SPAN) begin
      sig_idx = '1;
    end else begin
      sig_idx = z_off[lri_pkg::SIG_IDX_MSB -: lri_pkg::SIG_IDX_W];
    end
    entry.class_one = ~acc_i[lri_pkg::ACC_W-1];
    entry.prob_one  = lri_pkg::SIG_TABLE[sig_idx];
    entry.batch_end = done_i.batch_last;
  end

  assign push = done_i.vld;
  assign pop  = out_valid_o & ~out_stall_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q + lri_pkg::RES_CNT_W'(push) - lri_pkg::RES_CNT_W'(pop);
    cred_d   = cred_q + lri_pkg::RES_CNT_W'(claim_i) - lri_pkg::RES_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      cred_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
      cred_q   <= cred_d;
    end
  end

  assign head            = fifo_q[rd_ptr_q];
  assign full_o          = (cred_q == lri_pkg::RES_CNT_W'(lri_pkg::RES_DEPTH));
  assign out_valid_o     = (fill_q != '0);
  assign out_class_one_o = head.class_one;
  assign out_prob_one_o  = head.prob_one;
  assign out_prob_zero_o = ~head.prob_one;
  assign out_batch_end_o = head.batch_end;

  a_fill_within_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cred_q)
    else $error("queued results exceed claimed results");

  a_credit_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cred_q <= lri_pkg::RES_CNT_W'(lri_pkg::RES_DEPTH))
    else $error("result credit overflow");

endmodule

### design/logistic_regression_inference.sv
// Top level: streaming logistic regression inference with weight store and sigmoid table.
// Path: a sample's result passes the input and weight read registers, the product, the
// accumulator and the result queue. Throughput: one item per cycle while not stalled;
// an 8-entry result queue absorbs output stall before input stall rises.
// Reset: accumulator, feature position and result queue clear; bias 0, feature_count 1.
// The weight store is not cleared and holds undefined data until written.
module logistic_regression_inference (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   in_kind_i,
  input  logic        [lri_pkg::WIDX_W-1:0]      in_weight_index_i,
  input  logic signed [lri_pkg::VAL_W-1:0]       in_value_i,
  input  logic                                   in_last_sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   out_class_one_o,
  output logic        [lri_pkg::PROB_W-1:0]      out_prob_one_o,
  output logic        [lri_pkg::PROB_W-1:0]      out_prob_zero_o,
  output logic                                   out_batch_end_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic        [lri_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic        [lri_pkg::VAL_W-1:0]       cfg_data_i
);

  logic signed [lri_pkg::VAL_W-1:0]   bias_q;
  logic        [lri_pkg::FC_W-1:0]    fc_q;
  logic        [lri_pkg::POS_W-1:0]   pos_q, pos_d;
  logic        [lri_pkg::CNT_W-1:0]   cnt_eff;
  logic                               accept, feat_acc, wgt_wr, is_final, full;
  lri_pkg::tag_t                      tag_q, tag_d;
  logic signed [lri_pkg::VAL_W-1:0]   val_q;
  logic signed [lri_pkg::VAL_W-1:0]   weight;
  logic signed [lri_pkg::ACC_W-1:0]   acc;
  lri_pkg::done_t                     done;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= '0;
      fc_q   <= lri_pkg::FC_W'(1);
    end else if (cfg_valid_i) begin
      unique case (lri_pkg::cfg_reg_e'(cfg_index_i))
        lri_pkg::CFG_BIAS:          bias_q <= cfg_data_i;
        lri_pkg::CFG_FEATURE_COUNT: fc_q   <= cfg_data_i[lri_pkg::FC_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (fc_q == '0) begin
      cnt_eff = lri_pkg::CNT_W'(1);
    end else if (32'(fc_q) > lri_pkg::MAX_FEATURES) begin
      cnt_eff = lri_pkg::CNT_W'(lri_pkg::MAX_FEATURES);
    end else begin
      cnt_eff = lri_pkg::CNT_W'(fc_q);
    end
    accept   = in_valid_i & ~in_stall_o;
    feat_acc = accept & (lri_pkg::kind_e'(in_kind_i) == lri_pkg::KIND_FEATURE);
    wgt_wr   = accept & (lri_pkg::kind_e'(in_kind_i) == lri_pkg::KIND_WEIGHT)
             & (32'(in_weight_index_i) < lri_pkg::MAX_FEATURES);
    is_final = (32'(pos_q) + 32'd1 >= 32'(cnt_eff));
    pos_d    = pos_q;
    if (feat_acc) begin
      pos_d = is_final ? '0 : pos_q + 1'b1;
    end
    tag_d.vld        = feat_acc;
    tag_d.first      = (pos_q == '0);
    tag_d.fin        = is_final;
    tag_d.batch_last = in_last_sample_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      tag_q <= '0;
    end else begin
      pos_q <= pos_d;
      tag_q <= tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (feat_acc) begin
      val_q <= in_value_i;
    end
  end

  assign in_stall_o = full;

  lri_weight_mem u_weight_mem (
    .clk_i   (clk_i),
    .we_i    (wgt_wr),
    .waddr_i (lri_pkg::POS_W'(in_weight_index_i)),
    .wdata_i (in_value_i),
    .re_i    (feat_acc),
    .raddr_i (pos_q),
    .rdata_o (weight)
  );

  lri_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (tag_q),
    .value_i  (val_q),
    .weight_i (weight),
    .bias_i   (bias_q),
    .acc_o    (acc),
    .done_o   (done)
  );

  lri_out_stage u_out_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .acc_i           (acc),
    .done_i          (done),
    .claim_i         (feat_acc & is_final),
    .full_o          (full),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_class_one_o (out_class_one_o),
    .out_prob_one_o  (out_prob_one_o),
    .out_prob_zero_o (out_prob_zero_o),
    .out_batch_end_o (out_batch_end_o)
  );

  a_final_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    feat_acc && is_final |=> pos_q == '0)
    else $error("feature position not rewound after final feature");

endmodule

### test/tb.sv
// Self-checking testbench for the streaming logistic regression inference block.
`timescale 1ns / 1ps

module tb;

  localparam longint ACC_TOP = (longint'(1) <<< 39) - 1;
  localparam longint ACC_BOTTOM = -ACC_TOP - 1;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned E_INV_Q30 = 64'd395007542;
  localparam int SETTLE = 8;
  localparam int ITEMS_PER_PHASE = 178;

  typedef struct {
    logic        class_one;
    logic [15:0] prob_one;
    logic [15:0] prob_zero;
    logic        batch_end;
  } score_t;

  class logit_scorer;
    logic [15:0]        sig_lut[lri_pkg::SIGMOID_ENTRIES];
    logic signed [15:0] weights[lri_pkg::MAX_FEATURES];
    logic signed [15:0] bias;
    logic [6:0]         count;
    longint             acc;
    int                 pos;
    score_t             score_q[$];
    int unsigned        mismatches;

    function new();
      int                d;
      longint unsigned   mag, a, n, f, e, term, r, den, num;
      for (int k = 0; k < lri_pkg::SIGMOID_ENTRIES; k++) begin
        d = 2 * k + 1 - lri_pkg::SIGMOID_ENTRIES;
        mag = (d >= 0) ? d : -d;
        a = (mag << 33) / lri_pkg::SIGMOID_ENTRIES;
        n = a >> 30;
        f = a & (ONE_Q30 - 1);
        e = ONE_Q30;
        term = ONE_Q30;
        for (longint unsigned j = 1; j <= 24; j++) begin
          term = ((term * f) >> 30) / j;
          e = e + term;
        end
        r = (64'd1 << 60) / e;
        for (longint unsigned j = 0; j < n; j++) begin
          r = (r * E_INV_Q30) >> 30;
        end
        den = ONE_Q30 + r;
        num = (d >= 0) ? 64'd65535 * ONE_Q30 : 64'd65535 * r;
        sig_lut[k] = 16'((num + den / 2) / den);
      end
      bias = '0;
      count = 7'd1;
      acc = 0;
      pos = 0;
      mismatches = 0;
    endfunction

    function void set_reg(lri_pkg::cfg_reg_e idx, logic [15:0] data);
      if (idx == lri_pkg::CFG_BIAS) begin
        bias = signed'(data);
      end else begin
        count = data[6:0];
      end
    endfunction

    function void take_item(lri_pkg::kind_e kind, logic [5:0] widx, logic signed [15:0] val,
                            logic last);
      int     lim;
      longint sum;
      longint t;
      int     idx;
      score_t s;
      if (kind == lri_pkg::KIND_WEIGHT) begin
        weights[widx] = val;
        return;
      end
      lim = (count == 0) ? 1 :
            (count > lri_pkg::MAX_FEATURES) ? lri_pkg::MAX_FEATURES : int'(count);
      sum = ((pos == 0) ? longint'(bias) * 4096 : acc) + longint'(val) * longint'(weights[pos]);
      if (sum > ACC_TOP) begin
        sum = ACC_TOP;
      end else if (sum < ACC_BOTTOM) begin
        sum = ACC_BOTTOM;
      end
      acc = sum;
      if (pos + 1 < lim) begin
        pos++;
        return;
      end
      pos = 0;
      t = acc + (longint'(8) <<< 24);
      if (t < 0) begin
        idx = 0;
      end else if (t >= (longint'(1) <<< 28)) begin
        idx = lri_pkg::SIGMOID_ENTRIES - 1;
      end else begin
        idx = int'((t * lri_pkg::SIGMOID_ENTRIES) >>> 28);
      end
      s.class_one = (acc >= 0);
      s.prob_one = sig_lut[idx];
      s.prob_zero = 16'd65535 - sig_lut[idx];
      s.batch_end = last;
      score_q.push_back(s);
    endfunction

    function void flag(string name, longint want, longint got);
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    endfunction

    function void match_score(logic c, logic [15:0] p1, logic [15:0] p0, logic be);
      score_t want;
      if (score_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual class %0d p1 %0d p0 %0d",
                 $time, c, p1, p0);
        mismatches++;
        return;
      end
      want = score_q.pop_front();
      if (want.class_one !== c) flag("class_one", want.class_one, c);
      if (want.prob_one !== p1) flag("prob_one", want.prob_one, p1);
      if (want.prob_zero !== p0) flag("prob_zero", want.prob_zero, p0);
      if (want.batch_end !== be) flag("batch_end", want.batch_end, be);
    endfunction

    function int pending_count();
      return score_q.size();
    endfunction
  endclass

  logic                                clk_i;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic                                in_kind_i = 1'b0;
  logic [lri_pkg::WIDX_W-1:0]          in_weight_index_i = '0;
  logic signed [lri_pkg::VAL_W-1:0]    in_value_i = '0;
  logic                                in_last_sample_i = 1'b0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic                                out_class_one_o;
  logic [lri_pkg::PROB_W-1:0]          out_prob_one_o;
  logic [lri_pkg::PROB_W-1:0]          out_prob_zero_o;
  logic                                out_batch_end_o;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [lri_pkg::CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [lri_pkg::VAL_W-1:0]           cfg_data_i = '0;

  int   idle_pct = 7;
  logic quiet = 1'b0;

  logit_scorer scorer = new();

  logistic_regression_inference dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_kind_i         (in_kind_i),
    .in_weight_index_i (in_weight_index_i),
    .in_value_i        (in_value_i),
    .in_last_sample_i  (in_last_sample_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_class_one_o   (out_class_one_o),
    .out_prob_one_o    (out_prob_one_o),
    .out_prob_zero_o   (out_prob_zero_o),
    .out_batch_end_o   (out_batch_end_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 7);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      scorer.take_item(lri_pkg::kind_e'(in_kind_i), in_weight_index_i, in_value_i,
                       in_last_sample_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      scorer.match_score(out_class_one_o, out_prob_one_o, out_prob_zero_o, out_batch_end_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      scorer.set_reg(lri_pkg::cfg_reg_e'(cfg_index_i), cfg_data_i);
    end
  end

  function automatic logic signed [15:0] rand_q();
    case ($urandom_range(7))
      0, 1:    return 16'($urandom);
      2:       return ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($urandom_range(8192)) - 16'sd4096;
    endcase
  endfunction

  task automatic send_item(logic kind, logic [5:0] widx, logic signed [15:0] val,
                           logic last);
    int idle;
    idle = 0;
    while ($urandom_range(99) < idle_pct) idle++;
    if (idle != 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_kind_i <= kind;
    in_weight_index_i <= widx;
    in_value_i <= val;
    in_last_sample_i <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_feature(logic signed [15:0] val, logic last);
    send_item(lri_pkg::KIND_FEATURE, 6'($urandom), val, last);
  endtask

  // hold off until every pending transaction has produced its result
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (scorer.pending_count() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(lri_pkg::cfg_reg_e idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(logic signed [15:0] b, logic [6:0] cnt);
    drain();
    write_reg(lri_pkg::CFG_BIAS, b);
    write_reg(lri_pkg::CFG_FEATURE_COUNT, {9'd0, cnt});
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < lri_pkg::MAX_FEATURES; i++) begin
      send_item(lri_pkg::KIND_WEIGHT, 6'(i), (i == 0) ? 16'sh8000 : rand_q(), 1'($urandom));
    end

    configure(16'sh7FFF, 7'd1);
    send_feature(16'sh7FFF, 1'b1);
    send_feature(16'sh8000, 1'b0);
    send_feature(16'sh0000, 1'b1);

    // weight rewrite lands between features of one sample
    configure(16'sh8000, 7'd3);
    send_feature(16'sh1000, 1'b0);
    send_item(lri_pkg::KIND_WEIGHT, 6'd1, 16'sh7FFF, 1'b1);
    send_feature(16'sh7FFF, 1'b1);
    send_feature(16'sh0800, 1'b0);
    send_feature(16'shF000, 1'b1);

    // bias changes after the second feature of a sample
    send_feature(16'sh2000, 1'b0);
    configure(16'sh0000, 7'd3);
    send_feature(16'sh0400, 1'b0);
    send_feature(16'shC000, 1'b1);

    // count lowered below the current position
    configure(16'sh0000, 7'd4);
    send_feature(16'sh0100, 1'b0);
    send_feature(16'shFF00, 1'b0);
    configure(16'sh0000, 7'd2);
    send_feature(16'sh1234, 1'b1);

    configure(16'sh0400, 7'd0);
    send_feature(16'sh0FFF, 1'b0);
    send_feature(16'shF001, 1'b1);

    // probe the sigmoid table center and both edges
    send_item(lri_pkg::KIND_WEIGHT, 6'd0, 16'sh1000, 1'b0);
    configure(16'sh0000, 7'd1);
    send_feature(16'sh0000, 1'b0);
    send_feature(16'shFFFF, 1'b1);
    send_feature(16'sh8000, 1'b0);
    send_feature(16'sh7FFF, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       configure(16'sh8000, 7'd64);
        1:       configure(16'sh7FFF, 7'd127);
        2:       configure(16'($urandom), 7'd1);
        5:       configure(16'($urandom), 7'($urandom_range(1, 64)));
        default: configure(16'($urandom), 7'($urandom_range(2, 8)));
      endcase
      quiet = (ph == 3);
      idle_pct = (ph == 3) ? 0 : 7;
      repeat (ITEMS_PER_PHASE) begin
        send_item(($urandom_range(99) < 15) ? lri_pkg::KIND_WEIGHT : lri_pkg::KIND_FEATURE,
                  6'($urandom), rand_q(), 1'($urandom));
      end
    end

    quiet = 1'b0;
    idle_pct = 7;
    drain();
    if (scorer.mismatches == 0 && scorer.pending_count() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/lri_pkg.sv
design/lri_weight_mem.sv
design/lri_mac.sv
design/lri_out_stage.sv
design/logistic_regression_inference.sv
test/tb.sv
